>>> hw/rtl/srtt_pkg.sv
// Package for the sorted range translation table: constants, codes and state types.
package srtt_pkg;

   localparam int unsigned TableEntriesDefault = 256;
   localparam int unsigned ProbeDepthDefault   = 8;

   localparam int unsigned AddrWidth   = 64;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned UsedWidth   = 9;

   // Action codes on the request channel.
   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_FINALIZE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP   = 2'd2;

   // Status codes on the response channel.
   localparam logic [2:0] ST_HIT   = 3'd0;
   localparam logic [2:0] ST_MISS  = 3'd1;
   localparam logic [2:0] ST_KEPT  = 3'd2;
   localparam logic [2:0] ST_DROP  = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      // Insert: scan for position, then shift entries up.
      S_INS_RD,
      S_INS_CMP,
      S_SHF_RD,
      S_SHF_WR,
      S_INS_WR,
      // Finalize filter.
      S_FLT_RD,
      S_FLT_CHK,
      // Finalize insertion sort.
      S_SRT_RDI,
      S_SRT_LDI,
      S_SRT_RDJ,
      S_SRT_CMP,
      S_SRT_PUT,
      // Lookup: binary search then back-probes.
      S_BS_RD,
      S_BS_CMP,
      S_PR_RD,
      S_PR_CHK,
      S_RESP
   } state_type;

endpackage

>>> hw/rtl/sorted_range_translation_table.sv
// Top level of the sorted range translation table with its sequencer and range memory.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/req_stall action, virtual_address, file_offset, length
//   rsp_      out        rsp_valid/rsp_stall status, translated_offset, entries_used
//   csr_      in         csr_write_enable    csr_write_data (file_size)
//
// One transaction is processed at a time; req_stall is high until the response is taken.
// Lookup runs a binary search and then up to PROBE_DEPTH back-probes.
// Insert appends until finalized, then scans for its position and shifts later entries up.
// Finalize filters the entries against file_size, then runs an insertion sort over the one
// memory read port, one comparison or moved entry at a time.
// Reset clears the entry count, the finalized flag and file_size; the memory is not cleared.
// A stalled response holds its payload; no new request is taken while it waits.
module sorted_range_translation_table #(
   parameter int unsigned TABLE_ENTRIES = srtt_pkg::TableEntriesDefault,
   parameter int unsigned PROBE_DEPTH   = srtt_pkg::ProbeDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_virtual_address,
   input  logic [63:0] req_file_offset,
   input  logic [63:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_translated_offset,
   output logic [8:0]  rsp_entries_used,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned PrbW = $clog2(PROBE_DEPTH + 1);
   localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

   // Range memory, one write and one registered read port.
   logic [191:0] mem [TABLE_ENTRIES];
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic            wr_en;
   logic [191:0]    wr_data, rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   logic [63:0] rd_s, rd_o, rd_l;
   assign rd_s = rd_data_ff[191:128];
   assign rd_o = rd_data_ff[127:64];
   assign rd_l = rd_data_ff[63:0];

   srtt_pkg::state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            sealed_ff, sealed_in;
   logic [63:0]     fsize_ff;
   logic [1:0]      act_ff, act_in;
   logic [63:0]     va_ff, va_in, off_ff, off_in, len_ff, len_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, hi_ff, hi_in;
   logic [PrbW-1:0] pr_ff, pr_in;
   logic [2:0]      st_ff, st_in;
   logic [63:0]     tr_ff, tr_in;
   // Shared comparator operands and result.
   logic [63:0]     cs_a, cl_a, cs_b, cl_b;
   logic            ahead;

   // Shared ordering compare: true when range a goes ahead of range b.
   assign ahead = (cs_a != cs_b) ? (cs_a < cs_b) : (cl_a > cl_b);

   // Shared adder for the wrap checks; subtractors for the displacement and the room in a range.
   logic [64:0] sum;
   logic [63:0] disp, room;
   assign sum  = {1'b0, va_ff} + {1'b0, len_ff};
   assign disp = va_ff - rd_s;
   assign room = rd_l - disp;

   logic [CntW-1:0] mid;
   assign mid = i_ff + ((hi_ff - i_ff) >> 1);

   logic fits;
   assign fits = (rd_o <= fsize_ff) && (rd_l <= fsize_ff - rd_o);

   always_ff @(posedge clock) begin
      if (reset) begin
         fsize_ff <= '0;
      end else if (csr_write_enable) begin
         fsize_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srtt_pkg::S_IDLE;
         count_ff  <= '0;
         sealed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sealed_ff <= sealed_in;
      end
      act_ff <= act_in; va_ff <= va_in; off_ff <= off_in; len_ff <= len_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; hi_ff <= hi_in; pr_ff <= pr_in;
      st_ff <= st_in; tr_ff <= tr_in;
   end

   // Next state and datapath updates.
   always_comb begin
      state_in = state_ff; count_in = count_ff; sealed_in = sealed_ff;
      act_in = act_ff; va_in = va_ff; off_in = off_ff; len_in = len_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; hi_in = hi_ff; pr_in = pr_ff;
      st_in = st_ff; tr_in = tr_ff;
      cs_a = va_ff; cl_a = len_ff; cs_b = rd_s; cl_b = rd_l;
      case (state_ff)
         srtt_pkg::S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; va_in = req_virtual_address;
               off_in = req_file_offset; len_in = req_length;
               state_in = srtt_pkg::S_DISPATCH;
            end
         end
         srtt_pkg::S_DISPATCH: begin
            tr_in = '0;
            st_in = srtt_pkg::ST_MISS;
            state_in = srtt_pkg::S_RESP;
            case (act_ff)
               srtt_pkg::ACT_INSERT: begin
                  st_in = srtt_pkg::ST_DROP;
                  if (len_ff != 0 && va_ff != 0 && count_ff < Full && !sum[64]) begin
                     i_in = '0;
                     if (sealed_ff) state_in = srtt_pkg::S_INS_RD;
                     else begin
                        k_in = count_ff;
                        state_in = srtt_pkg::S_INS_WR;
                     end
                  end
               end
               srtt_pkg::ACT_FINALIZE: begin
                  i_in = '0; k_in = '0;
                  state_in = srtt_pkg::S_FLT_RD;
               end
               srtt_pkg::ACT_LOOKUP: begin
                  if (sealed_ff && count_ff != 0 && len_ff != 0 && !sum[64]) begin
                     i_in = '0; hi_in = count_ff;
                     state_in = srtt_pkg::S_BS_RD;
                  end
               end
               default: ;
            endcase
         end
         // Find the first entry the new range goes ahead of.
         srtt_pkg::S_INS_RD: begin
            if (i_ff == count_ff) begin
               k_in = count_ff; j_in = count_ff;
               state_in = srtt_pkg::S_INS_WR;
            end else state_in = srtt_pkg::S_INS_CMP;
         end
         srtt_pkg::S_INS_CMP: begin
            if (ahead) begin
               k_in = i_ff; j_in = count_ff;
               state_in = srtt_pkg::S_SHF_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = srtt_pkg::S_INS_RD;
            end
         end
         // Move entries k..count-1 up one slot, from the top down.
         srtt_pkg::S_SHF_RD: begin
            if (j_ff == k_ff) state_in = srtt_pkg::S_INS_WR;
            else state_in = srtt_pkg::S_SHF_WR;
         end
         srtt_pkg::S_SHF_WR: begin
            j_in = j_ff - 1'b1;
            state_in = srtt_pkg::S_SHF_RD;
         end
         srtt_pkg::S_INS_WR: begin
            count_in = count_ff + 1'b1;
            st_in = srtt_pkg::ST_KEPT;
            state_in = srtt_pkg::S_RESP;
         end
         // Filter: compact entries that fit the file.
         srtt_pkg::S_FLT_RD: begin
            if (i_ff == count_ff) begin
               count_in = k_ff; i_in = CntW'(1);
               state_in = srtt_pkg::S_SRT_RDI;
            end else state_in = srtt_pkg::S_FLT_CHK;
         end
         srtt_pkg::S_FLT_CHK: begin
            if (fits) k_in = k_ff + 1'b1;
            i_in = i_ff + 1'b1;
            state_in = srtt_pkg::S_FLT_RD;
         end
         // Insertion sort: hold entry i in va/off/len, walk j down.
         srtt_pkg::S_SRT_RDI: begin
            if (i_ff >= count_ff) begin
               sealed_in = 1'b1;
               st_in = srtt_pkg::ST_FINAL;
               state_in = srtt_pkg::S_RESP;
            end else state_in = srtt_pkg::S_SRT_LDI;
         end
         srtt_pkg::S_SRT_LDI: begin
            va_in = rd_s; off_in = rd_o; len_in = rd_l;
            j_in = i_ff;
            state_in = srtt_pkg::S_SRT_RDJ;
         end
         srtt_pkg::S_SRT_RDJ: begin
            if (j_ff == 0) state_in = srtt_pkg::S_SRT_PUT;
            else state_in = srtt_pkg::S_SRT_CMP;
         end
         srtt_pkg::S_SRT_CMP: begin
            if (ahead) begin
               j_in = j_ff - 1'b1;
               state_in = srtt_pkg::S_SRT_RDJ;
            end else state_in = srtt_pkg::S_SRT_PUT;
         end
         srtt_pkg::S_SRT_PUT: begin
            i_in = i_ff + 1'b1;
            state_in = srtt_pkg::S_SRT_RDI;
         end
         // Binary search for the first start above the address.
         srtt_pkg::S_BS_RD: begin
            if (i_ff < hi_ff) state_in = srtt_pkg::S_BS_CMP;
            else begin
               pr_in = '0;
               state_in = srtt_pkg::S_PR_RD;
            end
         end
         srtt_pkg::S_BS_CMP: begin
            if (va_ff < rd_s) hi_in = mid;
            else i_in = mid + 1'b1;
            state_in = srtt_pkg::S_BS_RD;
         end
         // Back-probes.
         srtt_pkg::S_PR_RD: begin
            if (pr_ff < PrbW'(PROBE_DEPTH) && i_ff != 0) begin
               i_in = i_ff - 1'b1;
               state_in = srtt_pkg::S_PR_CHK;
            end else state_in = srtt_pkg::S_RESP;
         end
         srtt_pkg::S_PR_CHK: begin
            if (disp < rd_l && room >= len_ff) begin
               st_in = srtt_pkg::ST_HIT;
               tr_in = rd_o + disp;
               state_in = srtt_pkg::S_RESP;
            end else begin
               pr_in = pr_ff + 1'b1;
               state_in = srtt_pkg::S_PR_RD;
            end
         end
         srtt_pkg::S_RESP: begin
            if (!rsp_stall) state_in = srtt_pkg::S_IDLE;
         end
         default: state_in = srtt_pkg::S_IDLE;
      endcase
   end

   // Memory addressing and write controls per state.
   always_comb begin
      rd_addr = i_ff[IdxW-1:0];
      wr_en   = 1'b0;
      wr_addr = k_ff[IdxW-1:0];
      wr_data = {va_ff, off_ff, len_ff};
      case (state_ff)
         srtt_pkg::S_SHF_RD: rd_addr = IdxW'(j_ff - 1'b1);
         srtt_pkg::S_SHF_WR: begin
            wr_en = 1'b1; wr_addr = j_ff[IdxW-1:0]; wr_data = rd_data_ff;
         end
         srtt_pkg::S_INS_WR: wr_en = 1'b1;
         srtt_pkg::S_FLT_CHK: begin
            wr_en = fits; wr_data = rd_data_ff;
         end
         srtt_pkg::S_SRT_RDJ: rd_addr = IdxW'(j_ff - 1'b1);
         srtt_pkg::S_SRT_CMP: begin
            wr_en = ahead; wr_addr = j_ff[IdxW-1:0]; wr_data = rd_data_ff;
         end
         srtt_pkg::S_SRT_PUT: begin
            wr_en = 1'b1; wr_addr = j_ff[IdxW-1:0];
         end
         srtt_pkg::S_BS_RD: rd_addr = mid[IdxW-1:0];
         srtt_pkg::S_PR_RD: rd_addr = IdxW'(i_ff - 1'b1);
         default: ;
      endcase
   end

   // Outputs.
   assign req_stall             = (state_ff != srtt_pkg::S_IDLE);
   assign rsp_valid             = (state_ff == srtt_pkg::S_RESP);
   assign rsp_status            = st_ff;
   assign rsp_translated_offset = tr_ff;
   assign rsp_entries_used      = 9'(count_ff);

   // Assertions.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full) else $error("entry count beyond table size");
   a_hit_sealed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == srtt_pkg::ST_HIT |-> sealed_ff)
      else $error("hit on unfinalized table");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != srtt_pkg::ST_HIT |-> rsp_translated_offset == 0)
      else $error("nonzero offset without hit");
   a_final_seals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == srtt_pkg::ST_FINAL |-> sealed_ff)
      else $error("finalize did not seal");

endmodule

>>> test/sorted_range_translation_table_tb.sv
// Testbench for the sorted range translation table: random and directed traffic with a scoreboard.
`timescale 1ns / 100ps

module sorted_range_translation_table_tb;

   localparam int unsigned TableSize   = 256;
   localparam int unsigned ProbeLimit  = 8;
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;
   localparam int unsigned TargetItems = 1400;
   localparam int unsigned CycleLimit  = 2000000;
   localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] offset;
      logic [8:0]  used;
   } answer_type;

   typedef struct {
      logic [63:0] start;
      logic [63:0] len;
   } span_type;

   // Scoreboard: keeps its own copy of the range table and the expected answers.
   class range_table_scoreboard;
      logic [63:0] starts [TableSize];
      logic [63:0] offs [TableSize];
      logic [63:0] lens [TableSize];
      int unsigned count;
      bit          sealed;
      logic [63:0] file_size;
      answer_type  pending_answers [$];
      int unsigned errors;
      int unsigned hits, misses, kept, dropped, finals;

      function new();
         count = 0;
         sealed = 0;
         file_size = '0;
         errors = 0;
         hits = 0;
         misses = 0;
         kept = 0;
         dropped = 0;
         finals = 0;
      endfunction

      // Order by start ascending, longer range first on equal starts.
      function bit goes_first(logic [63:0] sa, logic [63:0] la, logic [63:0] sb,
                              logic [63:0] lb);
         if (sa != sb) return sa < sb;
         return la > lb;
      endfunction

      function bit add_span(logic [63:0] va, logic [63:0] off, logic [63:0] len);
         logic [64:0] sum;
         int unsigned pos;
         sum = {1'b0, va} + {1'b0, len};
         if (len == 0 || va == 0 || count >= TableSize || sum[64]) return 0;
         pos = count;
         if (sealed) begin
            for (int unsigned i = 0; i < count; i++) begin
               if (goes_first(va, len, starts[i], lens[i])) begin
                  pos = i;
                  break;
               end
            end
            for (int unsigned i = count; i > pos; i--) begin
               starts[i] = starts[i-1];
               offs[i] = offs[i-1];
               lens[i] = lens[i-1];
            end
         end
         starts[pos] = va;
         offs[pos] = off;
         lens[pos] = len;
         count++;
         return 1;
      endfunction

      // Drop ranges that do not fit the file, then stable insertion sort.
      function void seal_spans();
         int unsigned k;
         logic [63:0] s, o, l;
         int unsigned j;
         k = 0;
         for (int unsigned i = 0; i < count; i++) begin
            if (offs[i] <= file_size && lens[i] <= file_size - offs[i]) begin
               starts[k] = starts[i];
               offs[k] = offs[i];
               lens[k] = lens[i];
               k++;
            end
         end
         count = k;
         for (int unsigned i = 1; i < count; i++) begin
            s = starts[i];
            o = offs[i];
            l = lens[i];
            j = i;
            while (j > 0 && goes_first(s, l, starts[j-1], lens[j-1])) begin
               starts[j] = starts[j-1];
               offs[j] = offs[j-1];
               lens[j] = lens[j-1];
               j--;
            end
            starts[j] = s;
            offs[j] = o;
            lens[j] = l;
         end
         sealed = 1;
      endfunction

      function bit translate(logic [63:0] va, logic [63:0] len, output logic [63:0] res);
         logic [64:0] sum;
         int unsigned lo, hi, mid;
         logic [63:0] disp;
         res = '0;
         sum = {1'b0, va} + {1'b0, len};
         if (!sealed || count == 0 || len == 0 || sum[64]) return 0;
         lo = 0;
         hi = count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (va < starts[mid]) hi = mid;
            else lo = mid + 1;
         end
         for (int unsigned step = 0; step < ProbeLimit && lo > 0; step++) begin
            lo--;
            disp = va - starts[lo];
            if (disp < lens[lo] && lens[lo] - disp >= len) begin
               res = offs[lo] + disp;
               return 1;
            end
         end
         return 0;
      endfunction

      // Note an accepted request and queue the answer it must produce.
      function void note_request(logic [1:0] act, logic [63:0] va, logic [63:0] off,
                                 logic [63:0] len);
         answer_type a;
         logic [63:0] r;
         a.status = srtt_pkg::ST_MISS;
         a.offset = '0;
         case (act)
            srtt_pkg::ACT_INSERT: begin
               a.status = add_span(va, off, len) ? srtt_pkg::ST_KEPT : srtt_pkg::ST_DROP;
               if (a.status == srtt_pkg::ST_KEPT) kept++;
               else dropped++;
            end
            srtt_pkg::ACT_FINALIZE: begin
               seal_spans();
               a.status = srtt_pkg::ST_FINAL;
               finals++;
            end
            srtt_pkg::ACT_LOOKUP: begin
               if (translate(va, len, r)) begin
                  a.status = srtt_pkg::ST_HIT;
                  a.offset = r;
                  hits++;
               end else begin
                  misses++;
               end
            end
            default: ;
         endcase
         a.used = count[8:0];
         pending_answers = {pending_answers, a};
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(logic [2:0] st, logic [63:0] off, logic [8:0] used);
         answer_type a;
         if (pending_answers.size() == 0) begin
            $error("response with nothing expected: status %0d", st);
            errors++;
            return;
         end
         a = pending_answers.pop_front();
         if (st !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, st);
            errors++;
         end
         if (off !== a.offset) begin
            $error("translated_offset: expected %h, got %h", a.offset, off);
            errors++;
         end
         if (used !== a.used) begin
            $error("entries_used: expected %0d, got %0d", a.used, used);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [63:0] req_virtual_address;
   logic [63:0] req_file_offset;
   logic [63:0] req_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_translated_offset;
   logic [8:0]  rsp_entries_used;
   logic        csr_write_enable;
   logic [63:0] csr_write_data;

   range_table_scoreboard board;
   span_type    known_spans [$];
   bit          calm;
   int unsigned sent;
   int unsigned cycles;

   sorted_range_translation_table uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_virtual_address   (req_virtual_address),
      .req_file_offset       (req_file_offset),
      .req_length            (req_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_translated_offset (rsp_translated_offset),
      .rsp_entries_used      (rsp_entries_used),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   // Clock with a 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Every accepted response is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_status, rsp_translated_offset, rsp_entries_used);
   end

   // Receiver: stalls each response at random, or not at all while calm is set.
   initial begin
      int unsigned hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Drive one transaction, after a random gap unless calm is set, and wait until it is taken.
   task automatic send(logic [1:0] act, logic [63:0] va, logic [63:0] off, logic [63:0] len);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_virtual_address <= va;
      req_file_offset <= off;
      req_length <= len;
      do @(posedge clock); while (req_stall);
      board.note_request(act, va, off, len);
      if (act == srtt_pkg::ACT_INSERT && len != 0 && va != 0)
         known_spans = {known_spans, span_type'{start: va, len: len}};
      sent++;
      @(negedge clock);
   endtask

   // Write file_size once every outstanding answer has arrived.
   task automatic write_file_size(logic [63:0] value);
      req_valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.file_size = value;
   endtask

   // Lookup aimed inside a known range most of the time.
   task automatic lookup_near();
      span_type sp;
      logic [63:0] disp, len;
      if (known_spans.size() == 0 || $urandom_range(0, 9) == 0) begin
         send(srtt_pkg::ACT_LOOKUP, rand64(), rand64(),
              $urandom_range(0, 3) == 0 ? rand64() : 64'd8);
         return;
      end
      sp = known_spans[$urandom_range(0, known_spans.size() - 1)];
      disp = (sp.len > 1) ? ({$urandom, $urandom} % sp.len) : 64'd0;
      len = $urandom_range(0, 3) == 0 ? sp.len - disp + $urandom_range(0, 1) :
            64'd1 + $urandom_range(0, 63);
      send(srtt_pkg::ACT_LOOKUP, sp.start + disp - $urandom_range(0, 1), rand64(), len);
   endtask

   initial begin
      logic [63:0] base, fsz;
      int unsigned n;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = srtt_pkg::ACT_INSERT;
      req_virtual_address = '0;
      req_file_offset = '0;
      req_length = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      calm = 0;
      sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: misses before finalize, unused action, insert drops and kept inserts.
      send(srtt_pkg::ACT_LOOKUP, 64'h1000, 64'd0, 64'd1);
      send(ACT_UNUSED, AllOnes, AllOnes, AllOnes);
      send(srtt_pkg::ACT_INSERT, 64'h1000, 64'd0, 64'd0);
      send(srtt_pkg::ACT_INSERT, 64'd0, 64'd0, 64'h10);
      send(srtt_pkg::ACT_INSERT, AllOnes, 64'd0, 64'd1);
      send(srtt_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000);
      send(srtt_pkg::ACT_INSERT, AllOnes - 1, AllOnes, 64'd1);
      send(srtt_pkg::ACT_INSERT, 64'h2000, 64'h100, 64'h100);
      send(srtt_pkg::ACT_INSERT, 64'h2000, 64'h500, 64'h200);
      send(srtt_pkg::ACT_INSERT, 64'h2000, 64'h900, 64'h100);
      send(srtt_pkg::ACT_INSERT, 64'h1000, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      send(srtt_pkg::ACT_LOOKUP, 64'h2000, 64'd0, 64'd1);
      // Fill the table to capacity, unsorted, then insert once more to reach the full drop.
      calm = 1;
      while (board.count < TableSize + 0)
         send(srtt_pkg::ACT_INSERT, rand64() | 64'd1, rand64() >> 8,
              64'd1 + $urandom_range(0, 4095));
      send(srtt_pkg::ACT_INSERT, 64'h3000, 64'd0, 64'd1);
      calm = 0;
      write_file_size(AllOnes);
      send(srtt_pkg::ACT_FINALIZE, '0, '0, '0);
      send(srtt_pkg::ACT_LOOKUP, 64'h2000, 64'd0, 64'd1);
      send(srtt_pkg::ACT_LOOKUP, 64'h20FF, 64'd0, 64'd2);
      send(srtt_pkg::ACT_LOOKUP, 64'h2000, 64'd0, 64'd0);
      send(srtt_pkg::ACT_LOOKUP, AllOnes, 64'd0, 64'd2);
      send(srtt_pkg::ACT_LOOKUP, AllOnes - 1, 64'd0, 64'd1);
      send(srtt_pkg::ACT_INSERT, 64'h3000, 64'd0, 64'd1);
      // Empty the table: nothing fits a zero-size file.
      write_file_size(64'd0);
      send(srtt_pkg::ACT_FINALIZE, '0, '0, '0);
      send(srtt_pkg::ACT_LOOKUP, 64'h2000, 64'd0, 64'd1);
      known_spans.delete();

      // Random phases, each with its own file size and window of addresses.
      while (sent < TargetItems) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: fsz = AllOnes;
            1: fsz = rand64();
            2: fsz = 64'd200000;
            default: fsz = 64'd1 + $urandom_range(0, 65535);
         endcase
         write_file_size(fsz);
         base = ($urandom_range(0, 3) == 0) ? (AllOnes - 64'd20000) : (rand64() >> 2);
         n = $urandom_range(2, 24);
         for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 11))
               0: send(srtt_pkg::ACT_INSERT, rand64(), rand64(), rand64());
               1: send(srtt_pkg::ACT_INSERT, base + 64'h100 * $urandom_range(0, 15),
                       {$urandom} % fsz, 64'h100 * $urandom_range(1, 3));
               default: send(srtt_pkg::ACT_INSERT, base + $urandom_range(0, 8191),
                             {$urandom} % 150000, 64'd1 + $urandom_range(0, 4095));
            endcase
            if ($urandom_range(0, 3) == 0) lookup_near();
         end
         send(srtt_pkg::ACT_FINALIZE, rand64(), rand64(), rand64());
         n = $urandom_range(10, 40);
         for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 15))
               0: send(srtt_pkg::ACT_INSERT, base + $urandom_range(0, 8191), rand64(),
                       64'd1 + $urandom_range(0, 4095));
               1: send(srtt_pkg::ACT_FINALIZE, rand64(), rand64(), rand64());
               2: send(ACT_UNUSED, rand64(), rand64(), rand64());
               default: lookup_near();
            endcase
         end
         // Clear out for the next phase.
         write_file_size(64'd0);
         send(srtt_pkg::ACT_FINALIZE, '0, '0, '0);
         known_spans.delete();
      end

      req_valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("Sent %0d transactions: %0d lookup hits, %0d misses, %0d finalizes.",
               sent, board.hits, board.misses, board.finals);
      $display("Inserts kept %0d, dropped %0d; mismatches %0d.",
               board.kept, board.dropped, board.errors);
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
